// File: rtl/trba_pkg.sv
// ----------------------------------------------------------------------------
// trba_pkg
// Shared types and constants of the tagged region bump allocator.
// ----------------------------------------------------------------------------
package trba_pkg;

   localparam int OFS_W       = 24;
   localparam int CMD_W       = 3;
   localparam int TAG_W       = 4;
   localparam int SIZE_W      = 24;
   localparam int COUNT_W     = 16;
   localparam int STATUS_W    = 2;
   localparam int NEED_W      = SIZE_W + COUNT_W;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_CREATE    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REQUEST   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd3;

   localparam logic [OFS_W-1:0] HEAP_CAPACITY_RESET = 24'hFFFFFF;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_MISSING,
      ST_EXISTS,
      ST_NOSPACE
   } status_type;

   typedef enum logic [2:0] {
      OP_CREATE,
      OP_REQUEST,
      OP_CLEAR,
      OP_CLEAR_ALL,
      OP_QUERY
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_EXEC
   } back_state_type;

   typedef struct packed {
      op_type               op;
      logic                 in_range;
      logic [TAG_W-1:0]     tag;
      logic [SIZE_W-1:0]    size;
      logic [COUNT_W-1:0]   count;
   } item_type;

   typedef struct packed {
      logic [OFS_W-1:0] base;
      logic [OFS_W-1:0] length;
      logic [OFS_W-1:0] next;
   } region_type;

endpackage

// File: rtl/trba_ram.sv
// ----------------------------------------------------------------------------
// trba_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module trba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/trba_front.sv
// ----------------------------------------------------------------------------
// trba_front
// Accepts commands, decodes them and checks the tag range, then holds them in
// a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module trba_front #(
   parameter int NUM_TAGS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_command,
   input  logic [3:0]                   req_tag_id,
   input  logic [23:0]                  req_size,
   input  logic [15:0]                  req_block_count,
   output logic                         q_valid,
   output trba_pkg::item_type           q_item,
   input  logic                         q_pop
);
   import trba_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         slot_ff [QUEUE_DEPTH];
   item_type         item_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   // classify the command; unused codes behave as query
   always_comb begin
      item_in.tag      = req_tag_id;
      item_in.size     = req_size;
      item_in.count    = req_block_count;
      item_in.in_range = (32'(req_tag_id) < NUM_TAGS);
      unique case (req_command)
         CMD_CREATE:    item_in.op = OP_CREATE;
         CMD_REQUEST:   item_in.op = OP_REQUEST;
         CMD_CLEAR:     item_in.op = OP_CLEAR;
         CMD_CLEAR_ALL: item_in.op = OP_CLEAR_ALL;
         default:       item_in.op = OP_QUERY;
      endcase
   end

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !q_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (q_pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// File: rtl/trba_back.sv
// ----------------------------------------------------------------------------
// trba_back
// Carries out one command at a time: reads the tag's region entry, forms the
// block product and the room left, then updates table, tag bits and used
// space and loads the result register.
// ----------------------------------------------------------------------------
module trba_back #(
   parameter int NUM_TAGS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [23:0]           heap_capacity,
   input  logic                  q_valid,
   input  trba_pkg::item_type    q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [23:0]           rsp_offset,
   output logic [23:0]           rsp_region_size,
   output logic [23:0]           rsp_next_free,
   output logic [23:0]           rsp_used_space
);
   import trba_pkg::*;

   localparam int TAG_IW = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
   localparam int XW     = (TAG_IW > TAG_W) ? TAG_IW : TAG_W;

   back_state_type      state_ff, state_in;
   item_type            cur_ff, cur_in;
   logic [NEED_W-1:0]   need_ff, need_in;
   logic [OFS_W:0]      left_ff, left_in;
   logic [NUM_TAGS-1:0] live_ff, live_in;
   logic [OFS_W-1:0]    claimed_ff, claimed_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [OFS_W-1:0]    offset_ff, offset_in;
   logic [OFS_W-1:0]    rsize_ff, rsize_in;
   logic [OFS_W-1:0]    rnext_ff, rnext_in;

   logic [XW-1:0]       q_tag_x, cur_tag_x;
   logic [TAG_IW-1:0]   q_idx, cur_idx, rd_addr;
   logic                cur_live;
   region_type          ent;
   region_type          wr_data;
   logic                wr_en;
   logic [OFS_W:0]      end_sum;
   logic [OFS_W-1:0]    avail;
   logic [OFS_W-1:0]    next_sum;

   assign q_tag_x   = XW'(q_item.tag);
   assign cur_tag_x = XW'(cur_ff.tag);
   assign q_idx     = q_tag_x[TAG_IW-1:0];
   assign cur_idx   = cur_tag_x[TAG_IW-1:0];
   assign rd_addr   = (state_ff == BK_IDLE) ? q_idx : cur_idx;
   assign cur_live  = cur_ff.in_range && live_ff[cur_idx];

   trba_ram #(
      .WIDTH ($bits(region_type)),
      .DEPTH (NUM_TAGS)
   ) u_region_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_idx),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ent)
   );

   assign end_sum  = {1'b0, ent.base} + {1'b0, ent.length};
   assign avail    = (heap_capacity > claimed_ff) ? heap_capacity - claimed_ff : '0;
   // next pointer wraps at the offset width
   assign next_sum = ent.next + need_ff[OFS_W-1:0];

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      need_in      = need_ff;
      left_in      = left_ff;
      live_in      = live_ff;
      claimed_in   = claimed_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_data      = ent;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      offset_in    = offset_ff;
      rsize_in     = rsize_ff;
      rnext_in     = rnext_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_item;
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            need_in  = NEED_W'(cur_ff.size) * NEED_W'(cur_ff.count);
            left_in  = (end_sum > {1'b0, ent.next}) ? end_sum - {1'b0, ent.next} : '0;
            state_in = BK_EXEC;
         end
         BK_EXEC: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in     = BK_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               offset_in    = '0;
               rsize_in     = '0;
               rnext_in     = '0;
               unique case (cur_ff.op)
                  OP_CREATE: begin
                     if (!cur_ff.in_range) begin
                        status_in = ST_MISSING;
                     end else if (cur_live) begin
                        status_in = ST_EXISTS;
                        rsize_in  = ent.length;
                        rnext_in  = ent.next;
                     end else if (OFS_W'(cur_ff.size) > avail) begin
                        status_in = ST_NOSPACE;
                     end else begin
                        wr_en          = 1'b1;
                        wr_data.base   = claimed_ff;
                        wr_data.length = OFS_W'(cur_ff.size);
                        wr_data.next   = claimed_ff;
                        live_in[cur_idx] = 1'b1;
                        claimed_in     = claimed_ff + OFS_W'(cur_ff.size);
                        offset_in      = claimed_ff;
                        rsize_in       = OFS_W'(cur_ff.size);
                        rnext_in       = claimed_ff;
                     end
                  end
                  OP_REQUEST: begin
                     if (!cur_live) begin
                        status_in = ST_MISSING;
                     end else if (need_ff > NEED_W'(left_ff)) begin
                        status_in = ST_NOSPACE;
                        rsize_in  = ent.length;
                        rnext_in  = ent.next;
                     end else begin
                        wr_en        = 1'b1;
                        wr_data.next = next_sum;
                        offset_in    = ent.next;
                        rsize_in     = ent.length;
                        rnext_in     = next_sum;
                     end
                  end
                  OP_CLEAR: begin
                     if (!cur_live) begin
                        status_in = ST_MISSING;
                     end else begin
                        claimed_in = (claimed_ff > ent.length) ? claimed_ff - ent.length : '0;
                        live_in[cur_idx] = 1'b0;
                     end
                  end
                  OP_CLEAR_ALL: begin
                     live_in    = '0;
                     claimed_in = '0;
                  end
                  OP_QUERY: begin
                     if (!cur_live) begin
                        status_in = ST_MISSING;
                     end else begin
                        rsize_in = ent.length;
                        rnext_in = ent.next;
                     end
                  end
                  default: begin
                     status_in = ST_MISSING;
                  end
               endcase
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         live_ff      <= '0;
         claimed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         claimed_ff   <= claimed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      need_ff   <= need_in;
      left_ff   <= left_in;
      status_ff <= status_in;
      offset_ff <= offset_in;
      rsize_ff  <= rsize_in;
      rnext_ff  <= rnext_in;
   end

   // used space is read straight from the running total, which only moves
   // in the cycle that also loads the result
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_offset      = offset_ff;
   assign rsp_region_size = rsize_ff;
   assign rsp_next_free   = rnext_ff;
   assign rsp_used_space  = claimed_ff;

endmodule

// File: rtl/tagged_region_bump_allocator.sv
// ----------------------------------------------------------------------------
// tagged_region_bump_allocator
// Table of tagged regions carved from one heap, with bump allocation inside
// each region.
// ----------------------------------------------------------------------------
// Each command (create, request, clear, clear all, query) yields exactly one
// response. The back end works on one command at a time: it reads the tag's
// region entry from the table RAM, then forms size times block_count and the
// room left in the region, then updates the table, the tag bits and the
// used-space total and loads the response register. A two-entry command
// queue in front keeps accepting, until it is full, while the back end works
// and while a response waits to be taken. Regions may overlap once a region
// other than the most recent one is cleared. heap_capacity should only be
// written while no command is in flight.
module tagged_region_bump_allocator #(
   parameter int NUM_TAGS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [23:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [3:0]  req_tag_id,
   input  logic [23:0] req_size,
   input  logic [15:0] req_block_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [23:0] rsp_offset,
   output logic [23:0] rsp_region_size,
   output logic [23:0] rsp_next_free,
   output logic [23:0] rsp_used_space
);
   import trba_pkg::*;

   logic [OFS_W-1:0] heap_capacity_ff, heap_capacity_in;
   logic             q_valid;
   logic             q_pop;
   item_type         q_item;

   assign heap_capacity_in = csr_write_en ? csr_write_data : heap_capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_capacity_ff <= HEAP_CAPACITY_RESET;
      end else begin
         heap_capacity_ff <= heap_capacity_in;
      end
   end

   trba_front #(
      .NUM_TAGS (NUM_TAGS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_tag_id      (req_tag_id),
      .req_size        (req_size),
      .req_block_count (req_block_count),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   trba_back #(
      .NUM_TAGS (NUM_TAGS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .heap_capacity   (heap_capacity_ff),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_offset      (rsp_offset),
      .rsp_region_size (rsp_region_size),
      .rsp_next_free   (rsp_next_free),
      .rsp_used_space  (rsp_used_space)
   );

   // a failed command never grants an offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_offset == '0))
      else $error("offset granted on a failed command");

   // a missing tag reports no region
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_MISSING) |->
         (rsp_region_size == '0) && (rsp_next_free == '0))
      else $error("missing tag reports a region");

   // no response is pending right after reset
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid right after reset");

   // a command never reaches the back end without a transfer in front of it
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

endmodule

// File: verif/tagged_region_bump_allocator_test.sv
// ----------------------------------------------------------------------------
// tagged_region_bump_allocator_test
// Self-checking bench for the tagged region allocator: a directed opening
// pass, then random command streams under several heap capacities, with
// bursty sending, patterned response stalls and a shadow model that scores
// every response field in order.
// ----------------------------------------------------------------------------
module tagged_region_bump_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import trba_pkg::*;

   localparam int TAGS = 1 << TAG_W;

   localparam logic [CMD_W-1:0] CMD_QUERY   = OP_QUERY;
   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

   localparam logic [OFS_W-1:0]   FULL_SIZE  = '1;
   localparam logic [COUNT_W-1:0] FULL_COUNT = '1;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [TAG_W-1:0]   tag;
      logic [SIZE_W-1:0]  size;
      logic [COUNT_W-1:0] count;
   } alloc_command_type;

   typedef struct packed {
      status_type       status;
      logic [OFS_W-1:0] offset;
      logic [OFS_W-1:0] region_size;
      logic [OFS_W-1:0] next_free;
      logic [OFS_W-1:0] used_space;
   } alloc_reply_type;

   typedef struct packed {
      logic [OFS_W-1:0]            capacity;
      logic [OFS_W-1:0]            claimed;
      logic [TAGS-1:0]             live;
      logic [TAGS-1:0][OFS_W-1:0]  base;
      logic [TAGS-1:0][OFS_W-1:0]  length;
      logic [TAGS-1:0][OFS_W-1:0]  next;
   } heap_model_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_en = 1'b0;
   logic [OFS_W-1:0]    csr_write_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_command = '0;
   logic [TAG_W-1:0]    req_tag_id = '0;
   logic [SIZE_W-1:0]   req_size = '0;
   logic [COUNT_W-1:0]  req_block_count = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [OFS_W-1:0]    rsp_offset;
   logic [OFS_W-1:0]    rsp_region_size;
   logic [OFS_W-1:0]    rsp_next_free;
   logic [OFS_W-1:0]    rsp_used_space;

   alloc_command_type pending_commands[$];
   alloc_reply_type   awaited_replies[$];
   alloc_command_type on_port;

   // plan_heap runs ahead at queueing time to steer the stimulus,
   // shadow_heap follows the transfers the block actually accepts
   heap_model_type  plan_heap;
   heap_model_type  shadow_heap;
   logic [TAGS-1:0] plan_written = '0;

   int fail_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;
   bit want_long_hold = 1'b0;

   tagged_region_bump_allocator dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_tag_id      (req_tag_id),
      .req_size        (req_size),
      .req_block_count (req_block_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_offset      (rsp_offset),
      .rsp_region_size (rsp_region_size),
      .rsp_next_free   (rsp_next_free),
      .rsp_used_space  (rsp_used_space)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic alloc_reply_type apply_command(inout heap_model_type m,
                                                     input alloc_command_type c);
      alloc_reply_type   r;
      logic [OFS_W-1:0]  free_bytes;
      logic [OFS_W:0]    region_end;
      logic [NEED_W-1:0] need;
      logic [NEED_W-1:0] room;
      r = '0;
      r.status = ST_OK;
      case (c.cmd)
         CMD_CREATE: begin
            free_bytes = (m.capacity > m.claimed) ? m.capacity - m.claimed : '0;
            if (m.live[c.tag]) begin
               r.status = ST_EXISTS;
            end else if (c.size > free_bytes) begin
               r.status = ST_NOSPACE;
            end else begin
               // new region always lands at the used-space mark
               m.base[c.tag] = m.claimed;
               m.length[c.tag] = c.size;
               m.next[c.tag] = m.claimed;
               m.live[c.tag] = 1'b1;
               m.claimed = m.claimed + c.size;
               r.offset = m.base[c.tag];
            end
         end
         CMD_REQUEST: begin
            if (!m.live[c.tag]) begin
               r.status = ST_MISSING;
            end else begin
               need = NEED_W'(c.size) * NEED_W'(c.count);
               region_end = {1'b0, m.base[c.tag]} + {1'b0, m.length[c.tag]};
               room = (region_end > {1'b0, m.next[c.tag]}) ?
                      NEED_W'(region_end - {1'b0, m.next[c.tag]}) : '0;
               if (need > room) begin
                  r.status = ST_NOSPACE;
               end else begin
                  r.offset = m.next[c.tag];
                  m.next[c.tag] = m.next[c.tag] + need[OFS_W-1:0];
               end
            end
         end
         CMD_CLEAR: begin
            if (!m.live[c.tag]) begin
               r.status = ST_MISSING;
            end else begin
               m.claimed = (m.claimed > m.length[c.tag]) ?
                           m.claimed - m.length[c.tag] : '0;
               m.live[c.tag] = 1'b0;
            end
         end
         CMD_CLEAR_ALL: begin
            m.live = '0;
            m.claimed = '0;
         end
         default: begin
            // query and the spare codes behave alike
            if (!m.live[c.tag]) r.status = ST_MISSING;
         end
      endcase
      if (m.live[c.tag]) begin
         r.region_size = m.length[c.tag];
         r.next_free = m.next[c.tag];
      end
      r.used_space = m.claimed;
      return r;
   endfunction

   task automatic queue_command(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] tag,
                                input logic [SIZE_W-1:0] size,
                                input logic [COUNT_W-1:0] count);
      alloc_command_type c;
      alloc_reply_type   r;
      c.cmd = cmd;
      c.tag = tag;
      c.size = size;
      c.count = count;
      r = apply_command(plan_heap, c);
      if (cmd == CMD_CREATE && r.status == ST_OK) plan_written[tag] = 1'b1;
      pending_commands.push_back(c);
   endtask

   // tags whose table entry was never filled only ever see a create
   task automatic queue_random_command();
      logic [TAG_W-1:0]   tag;
      logic [CMD_W-1:0]   cmd;
      logic [SIZE_W-1:0]  size;
      logic [COUNT_W-1:0] count;
      logic [OFS_W-1:0]   free_bytes;
      logic [OFS_W:0]     region_end;
      logic [OFS_W-1:0]   room;
      int pick;
      int shape;
      tag = TAG_W'($urandom_range(0, TAGS - 1));
      pick = $urandom_range(0, 99);
      shape = $urandom_range(0, 9);
      size = SIZE_W'($urandom);
      count = COUNT_W'($urandom);
      if (!plan_written[tag] || (!plan_heap.live[tag] && pick < 45)) begin
         cmd = CMD_CREATE;
         free_bytes = (plan_heap.capacity > plan_heap.claimed) ?
                      plan_heap.capacity - plan_heap.claimed : '0;
         if (shape < 6) size = SIZE_W'($urandom_range(1, 'h400));
         else if (shape == 6) size = '0;
         else if (shape == 8) size = free_bytes;
         else if (shape == 9) size = free_bytes + 1'b1;
      end else if (!plan_heap.live[tag]) begin
         case ($urandom_range(0, 2))
            0: cmd = CMD_REQUEST;
            1: cmd = CMD_CLEAR;
            default: cmd = CMD_W'($urandom_range(CMD_QUERY, CMD_SPARE_C));
         endcase
      end else if (pick < 55) begin
         cmd = CMD_REQUEST;
         region_end = {1'b0, plan_heap.base[tag]} + {1'b0, plan_heap.length[tag]};
         room = (region_end > {1'b0, plan_heap.next[tag]}) ?
                OFS_W'(region_end - {1'b0, plan_heap.next[tag]}) : '0;
         if (shape < 5) begin
            count = COUNT_W'($urandom_range(1, 8));
            size = SIZE_W'($urandom_range(0, room / count));
         end else if (shape == 5) begin
            count = COUNT_W'(1);
            size = room;
         end else if (shape == 6) begin
            count = COUNT_W'(1);
            size = room + 1'b1;
         end else if (shape == 7) begin
            if (pick[0]) size = '0;
            else count = '0;
         end
      end else if (pick < 67) begin
         cmd = CMD_W'($urandom_range(CMD_QUERY, CMD_SPARE_C));
      end else if (pick < 80) begin
         cmd = CMD_CLEAR;
      end else if (pick < 88) begin
         cmd = CMD_CREATE;
      end else if (pick < 91) begin
         cmd = CMD_CLEAR_ALL;
      end else begin
         cmd = CMD_REQUEST;
      end
      queue_command(cmd, tag, size, count);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_commands.size() != 0 || req_valid || awaited_replies.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_capacity(input logic [OFS_W-1:0] value);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      plan_heap.capacity = value;
      shadow_heap.capacity = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_phase(input logic [OFS_W-1:0] capacity, input int items,
                            input bit long_hold);
      set_capacity(capacity);
      repeat (items) queue_random_command();
      if (long_hold) want_long_hold = 1'b1;
      wait_drained();
   endtask

   task automatic check_field(input string name, input logic [OFS_W-1:0] want,
                              input logic [OFS_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // sender: bursts of transfers separated by random gaps
   always @(posedge clock) begin : sender
      alloc_reply_type reply;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            reply = apply_command(shadow_heap, on_port);
            awaited_replies.push_back(reply);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_commands.size() != 0) begin
               on_port = pending_commands.pop_front();
               req_command <= on_port.cmd;
               req_tag_id <= on_port.tag;
               req_size <= on_port.size;
               req_block_count <= on_port.count;
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with an occasional long hold-off
   always @(posedge clock) begin : stall_pattern
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (want_long_hold) begin
            want_long_hold = 1'b0;
            hold_left = 90;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 60);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   always @(posedge clock) begin : reply_checker
      alloc_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_replies.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, got status %0h offset %0h",
                     $time, rsp_status, rsp_offset);
            fail_count++;
         end else begin
            want = awaited_replies.pop_front();
            check_field("status", OFS_W'(want.status), OFS_W'(rsp_status));
            check_field("offset", want.offset, rsp_offset);
            check_field("region_size", want.region_size, rsp_region_size);
            check_field("next_free", want.next_free, rsp_next_free);
            check_field("used_space", want.used_space, rsp_used_space);
         end
      end
   end

   initial begin
      plan_heap = '0;
      plan_heap.capacity = HEAP_CAPACITY_RESET;
      shadow_heap = plan_heap;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_capacity(FULL_SIZE);
      queue_command(CMD_CREATE, 4'd0, 24'h100, FULL_COUNT);
      queue_command(CMD_CREATE, 4'd0, 24'h10, 16'h0);
      queue_command(CMD_CREATE, 4'd1, FULL_SIZE, 16'h0);
      queue_command(CMD_REQUEST, 4'd0, 24'h10, 16'd4);
      queue_command(CMD_REQUEST, 4'd0, FULL_SIZE, FULL_COUNT);
      queue_command(CMD_REQUEST, 4'd0, 24'h0, FULL_COUNT);
      queue_command(CMD_REQUEST, 4'd0, FULL_SIZE, 16'h0);
      // exactly fills the rest of the region, then one byte too many
      queue_command(CMD_REQUEST, 4'd0, 24'hC0, 16'd1);
      queue_command(CMD_REQUEST, 4'd0, 24'h1, 16'd1);
      queue_command(CMD_QUERY, 4'd0, 24'h0, 16'h0);
      queue_command(CMD_SPARE_A, 4'd0, FULL_SIZE, FULL_COUNT);
      queue_command(CMD_SPARE_B, 4'd0, 24'h0, 16'h0);
      queue_command(CMD_SPARE_C, 4'd0, 24'h0, 16'h0);
      queue_command(CMD_CREATE, 4'd1, 24'h80, 16'h0);
      queue_command(CMD_CREATE, 4'd2, 24'h40, 16'h0);
      // clearing a middle region lets the next create land inside tag 1's old space
      queue_command(CMD_CLEAR, 4'd1, 24'h0, 16'h0);
      queue_command(CMD_CREATE, 4'd3, 24'h20, 16'h0);
      queue_command(CMD_REQUEST, 4'd1, 24'h1, 16'd1);
      queue_command(CMD_QUERY, 4'd1, 24'h0, 16'h0);
      queue_command(CMD_CLEAR, 4'd1, 24'h0, 16'h0);
      queue_command(CMD_CLEAR_ALL, 4'd0, 24'h0, 16'h0);
      queue_command(CMD_CREATE, 4'd15, FULL_SIZE, 16'h0);
      queue_command(CMD_REQUEST, 4'd15, FULL_SIZE, 16'd1);
      queue_command(CMD_CLEAR_ALL, 4'd15, FULL_SIZE, FULL_COUNT);
      wait_drained();

      run_phase(FULL_SIZE, 220, 1'b1);
      // capacity dropped below what live regions already hold
      run_phase(plan_heap.claimed >> 1, 130, 1'b0);
      run_phase('0, 130, 1'b0);
      run_phase(24'h2000, 200, 1'b1);
      run_phase(OFS_W'($urandom), 170, 1'b0);

      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
